// File: src/xs128_pkg.sv
// Shared types and constants for the xorshift128 random source.
// Used by the front, queue, back and top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xs128_pkg;

    // Mode codes on the input port
    localparam logic [2:0] MODE_RESEED = 3'd0;
    localparam logic [2:0] MODE_RAW    = 3'd1;
    localparam logic [2:0] MODE_BOOL   = 3'd2;
    localparam logic [2:0] MODE_BOUND  = 3'd3;
    localparam logic [2:0] MODE_FLOAT  = 3'd4;

    localparam logic [31:0] SEED_MULT = 32'h6C07_8965;
    localparam logic [31:0] ONE_FLOAT = 32'h3F80_0000;

    localparam int SEED_SHIFT  = 30;
    localparam int XS_SHL      = 11;
    localparam int XS_SHR_N    = 8;
    localparam int XS_SHR_LAST = 19;
    localparam int FLOAT_SHIFT = 9;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_SEED,
        OP_RAW,
        OP_BOOL,
        OP_BOUND,
        OP_FLOAT
    } op_t;

    // One classified command word handed from front to back
    typedef struct packed {
        op_t                op;
        logic [31:0]        seed;
        logic signed [31:0] low;
        logic [31:0]        span;       // high - low + 1, low 32 bits
        logic               span_full;  // span is exactly 2^32
        logic               range_err;  // low > high
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SEED,
        B_MUL,
        B_DONE
    } back_state_t;

endpackage

`default_nettype wire

// File: src/xs128_front.sv
// Front end: takes input words, decodes the mode and forms the range span.
// Depends on xs128_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xs128_front (
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         mode,
    input  wire logic [31:0]        seed,
    input  wire logic signed [31:0] range_low,
    input  wire logic signed [31:0] range_high,
    input  wire logic               q_full,
    output logic                    q_push,
    output xs128_pkg::cmd_t         q_cmd
);

    logic [32:0] diff;
    logic [32:0] span;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Exact 33-bit span so the full signed range gives 2^32
    assign diff = {range_high[31], range_high} - {range_low[31], range_low};
    assign span = diff + 33'd1;

    always_comb
    begin
        q_cmd           = '0;
        q_cmd.seed      = seed;
        q_cmd.low       = range_low;
        q_cmd.span      = span[31:0];
        q_cmd.range_err = diff[32];
        q_cmd.span_full = !diff[32] && span[32];
        unique case (mode)
            xs128_pkg::MODE_RESEED: q_cmd.op = xs128_pkg::OP_SEED;
            xs128_pkg::MODE_BOOL:   q_cmd.op = xs128_pkg::OP_BOOL;
            xs128_pkg::MODE_BOUND:  q_cmd.op = xs128_pkg::OP_BOUND;
            xs128_pkg::MODE_FLOAT:  q_cmd.op = xs128_pkg::OP_FLOAT;
            default:                q_cmd.op = xs128_pkg::OP_RAW;
        endcase
    end

endmodule

`default_nettype wire

// File: src/xs128_queue.sv
// Small command queue between the front and back ends.
// Depends on xs128_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xs128_queue #(
    parameter int DEPTH = xs128_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire xs128_pkg::cmd_t push_cmd,
    output logic                 full,
    input  wire logic            pop,
    output logic                 empty,
    output xs128_pkg::cmd_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    xs128_pkg::cmd_t  entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: src/xs128_back.sv
// Back end: xorshift128 state, reseed multiply chain, range scaling and
// the output register. Depends on xs128_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xs128_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_empty,
    input  wire xs128_pkg::cmd_t    q_head,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [31:0]             raw_word,
    output logic                    bit_value,
    output logic signed [31:0]      bounded_value,
    output logic [31:0]             float_bits,
    output logic                    range_error
);

    xs128_pkg::back_state_t state_reg, state_next;

    logic [31:0]     words_reg [4];
    logic [31:0]     words_next [4];
    logic [31:0]     prev_reg, prev_next;
    logic [1:0]      seed_cnt_reg, seed_cnt_next;
    logic [31:0]     word_reg, word_next;
    logic [63:0]     prod_reg, prod_next;
    xs128_pkg::cmd_t cmd_reg, cmd_next;

    logic            out_valid_reg, out_valid_next;
    logic [31:0]     raw_reg, raw_next;
    logic            bit_reg, bit_next;
    logic [31:0]     bound_reg, bound_next;
    logic [31:0]     float_reg, float_next;
    logic            err_reg, err_next;

    logic [31:0]     xs_n;
    logic [31:0]     xs_word;
    logic [31:0]     mix;
    logic [31:0]     prod_hi;
    logic            load_out;

    assign out_valid     = out_valid_reg;
    assign raw_word      = raw_reg;
    assign bit_value     = bit_reg;
    assign bounded_value = bound_reg;
    assign float_bits    = float_reg;
    assign range_error   = err_reg;

    // One xorshift128 step
    assign xs_n    = words_reg[0] ^ (words_reg[0] << xs128_pkg::XS_SHL);
    assign xs_word = xs_n ^ (xs_n >> xs128_pkg::XS_SHR_N)
                   ^ words_reg[3] ^ (words_reg[3] >> xs128_pkg::XS_SHR_LAST);

    // One seed mixing step
    assign mix = xs128_pkg::SEED_MULT * (prev_reg ^ (prev_reg >> xs128_pkg::SEED_SHIFT))
               + 32'(seed_cnt_reg) + 32'd1;

    assign prod_hi  = cmd_reg.span_full ? word_reg : prod_reg[63:32];
    assign load_out = (state_reg == xs128_pkg::B_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next    = state_reg;
        words_next    = words_reg;
        prev_next     = prev_reg;
        seed_cnt_next = seed_cnt_reg;
        word_next     = word_reg;
        prod_next     = prod_reg;
        cmd_next      = cmd_reg;
        q_pop         = 1'b0;

        out_valid_next = out_valid_reg && !out_ready;
        raw_next       = raw_reg;
        bit_next       = bit_reg;
        bound_next     = bound_reg;
        float_next     = float_reg;
        err_next       = err_reg;

        unique case (state_reg)
            xs128_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                    if (q_head.op == xs128_pkg::OP_SEED)
                    begin
                        prev_next     = q_head.seed;
                        seed_cnt_next = '0;
                        state_next    = xs128_pkg::B_SEED;
                    end
                    else
                    begin
                        // advance the generator once
                        words_next[0] = words_reg[1];
                        words_next[1] = words_reg[2];
                        words_next[2] = words_reg[3];
                        words_next[3] = xs_word;
                        word_next     = xs_word;
                        if (q_head.op == xs128_pkg::OP_BOUND && !q_head.range_err
                            && !q_head.span_full)
                        begin
                            state_next = xs128_pkg::B_MUL;
                        end
                        else
                        begin
                            state_next = xs128_pkg::B_DONE;
                        end
                    end
                end
            end
            xs128_pkg::B_SEED:
            begin
                words_next[seed_cnt_reg] = mix;
                prev_next                = mix;
                seed_cnt_next            = seed_cnt_reg + 2'd1;
                if (seed_cnt_reg == 2'd3)
                begin
                    state_next = xs128_pkg::B_DONE;
                end
            end
            xs128_pkg::B_MUL:
            begin
                prod_next  = word_reg * cmd_reg.span;
                state_next = xs128_pkg::B_DONE;
            end
            xs128_pkg::B_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    raw_next       = '0;
                    bit_next       = 1'b0;
                    bound_next     = '0;
                    float_next     = '0;
                    err_next       = 1'b0;
                    unique case (cmd_reg.op)
                        xs128_pkg::OP_SEED:
                        begin
                        end
                        xs128_pkg::OP_RAW:
                        begin
                            raw_next = word_reg;
                        end
                        xs128_pkg::OP_BOOL:
                        begin
                            raw_next = word_reg;
                            bit_next = word_reg[31];
                        end
                        xs128_pkg::OP_BOUND:
                        begin
                            raw_next = word_reg;
                            if (cmd_reg.range_err)
                            begin
                                bound_next = cmd_reg.low;
                                err_next   = 1'b1;
                            end
                            else
                            begin
                                bound_next = cmd_reg.low + prod_hi;
                            end
                        end
                        xs128_pkg::OP_FLOAT:
                        begin
                            raw_next   = word_reg;
                            float_next = xs128_pkg::ONE_FLOAT
                                       | (word_reg >> xs128_pkg::FLOAT_SHIFT);
                        end
                        default:
                        begin
                            raw_next = word_reg;
                        end
                    endcase
                    state_next = xs128_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = xs128_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xs128_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            seed_cnt_reg  <= '0;
            words_reg     <= '{default: '0};
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            seed_cnt_reg  <= seed_cnt_next;
            words_reg     <= words_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg  <= prev_next;
        word_reg  <= word_next;
        prod_reg  <= prod_next;
        cmd_reg   <= cmd_next;
        raw_reg   <= raw_next;
        bit_reg   <= bit_next;
        bound_reg <= bound_next;
        float_reg <= float_next;
        err_reg   <= err_next;
    end

endmodule

`default_nettype wire

// File: src/xorshift128_random_source_top.sv
// Top level of the xorshift128 random source.
// Depends on xs128_pkg, xs128_front, xs128_queue and xs128_back.
`timescale 1ns / 1ps
`default_nettype none

// xorshift128 random source. Each input word picks a mode (reseed, raw word,
// boolean, bounded integer, float bits) and produces exactly one result word.
// After reset the state is all zero, which keeps the generator at zero:
// send a reseed first. The front end decodes the mode and forms the exact
// 33-bit range span, then drops the command into a short queue, so input
// words keep being taken while the back end works or a result waits at the
// output, until the queue fills. The back end takes one command at a time:
// raw, boolean and float draws go from idle to done, bounded draws pass a
// multiply state for the 32x32 scaling (a full-width range skips it), and a
// reseed runs its four mixing multiplies one per cycle through a
// single multiplier. Results sit in an output register until taken; a
// bounded request with low above high returns low with range_error set.
module xorshift128_random_source_top #(
    parameter int QUEUE_DEPTH = xs128_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         mode,
    input  wire logic [31:0]        seed,
    input  wire logic signed [31:0] range_low,
    input  wire logic signed [31:0] range_high,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [31:0]             raw_word,
    output logic                    bit_value,
    output logic signed [31:0]      bounded_value,
    output logic [31:0]             float_bits,
    output logic                    range_error
);

    // Front to queue
    logic            q_push;
    logic            q_full;
    xs128_pkg::cmd_t q_cmd;

    // Queue to back
    logic            q_pop;
    logic            q_empty;
    xs128_pkg::cmd_t q_head;

    // Decode and classify incoming words
    xs128_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .seed       (seed),
        .range_low  (range_low),
        .range_high (range_high),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    // Hold decoded commands until the back end is free
    xs128_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    // Advance the state, reseed, scale and register the result
    xs128_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .raw_word      (raw_word),
        .bit_value     (bit_value),
        .bounded_value (bounded_value),
        .float_bits    (float_bits),
        .range_error   (range_error)
    );

endmodule

`default_nettype wire

// File: src/xs128_checker.sv
// Port-level checks for the xorshift128 random source, bound to the top level.
// Depends on xorshift128_random_source_top.
`timescale 1ns / 1ps
`default_nettype none

module xs128_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [31:0]        raw_word,
    input wire logic               bit_value,
    input wire logic signed [31:0] bounded_value,
    input wire logic [31:0]        float_bits,
    input wire logic               range_error
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(raw_word)
            && $stable(bounded_value) && $stable(float_bits))
        else $error("result dropped or changed while stalled");

    // Boolean bit is the top bit of the word drawn with it
    a_bit_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bit_value |-> raw_word[31])
        else $error("bit_value disagrees with raw_word");

    // Range error only on a bounded result
    a_err_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> !bit_value && float_bits == 32'd0)
        else $error("range_error on a non-bounded result");

    // Float bits always encode a value in [1,2) built from the word
    a_float: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && float_bits != 32'd0 |->
            float_bits[31:23] == 9'h07F && float_bits[22:0] == raw_word[31:9])
        else $error("float_bits malformed");

endmodule

bind xorshift128_random_source_top xs128_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .raw_word      (raw_word),
    .bit_value     (bit_value),
    .bounded_value (bounded_value),
    .float_bits    (float_bits),
    .range_error   (range_error)
);

`default_nettype wire
